/* hw/rtl/cube_corner_transform_macros.svh */
// Assertion macros shared by the cube corner transform RTL
`ifndef CUBE_CORNER_TRANSFORM_MACROS_SVH
`define CUBE_CORNER_TRANSFORM_MACROS_SVH

// combinational property, checked out of reset
`define CCT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent this cycle, consequent next cycle
`define CCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/cct_pkg.sv */
// Package: constants, types and helpers of the cube corner transform
`default_nettype none

package cct_pkg;

  localparam int MAP_SIZE    = 64;
  localparam int VIEW_WIDTH  = 640;
  localparam int VIEW_HEIGHT = 480;

  localparam int TILE_W    = 6;
  localparam int CORNER_W  = 3;
  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int NSTG      = 7;

  localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(7);

  // datapath widths
  localparam int POS_W = 18;            // relative position, Q.8
  localparam int AX_W  = 34;            // after zoom, Q.16
  localparam int AY_W  = 25;            // y after zoom, Q.16
  localparam int PR_W  = AX_W + REG_W;  // yaw products, Q.30
  localparam int ROT_W = 36;            // after yaw, Q.16
  localparam int QA_W  = AY_W + REG_W;  // pitch products of y
  localparam int QR_W  = ROT_W + REG_W; // pitch products of rz
  localparam int W_W   = 38;            // after pitch, Q.16
  localparam int EXT_W = 40;            // output rounding and offset

  localparam logic [REG_W-1:0] RST_CAMERA_X = 16'd0;
  localparam logic [REG_W-1:0] RST_CAMERA_Y = 16'd0;
  localparam logic [REG_W-1:0] RST_ZOOM     = 16'd8192;
  localparam logic [REG_W-1:0] RST_COS_YAW  = 16'd16384;
  localparam logic [REG_W-1:0] RST_SIN_YAW  = 16'd0;
  localparam logic [REG_W-1:0] RST_COS_PIT  = 16'd16384;
  localparam logic [REG_W-1:0] RST_SIN_PIT  = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X  = 3'd0,
    REG_CAMERA_Y  = 3'd1,
    REG_ZOOM      = 3'd2,
    REG_COS_YAW   = 3'd3,
    REG_SIN_YAW   = 3'd4,
    REG_COS_PITCH = 3'd5,
    REG_SIN_PITCH = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [REG_W-1:0] camera_x;
    logic signed [REG_W-1:0] camera_y;
    logic        [REG_W-1:0] zoom_factor;
    logic signed [REG_W-1:0] cos_yaw;
    logic signed [REG_W-1:0] sin_yaw;
    logic signed [REG_W-1:0] cos_pitch;
    logic signed [REG_W-1:0] sin_pitch;
  } cfg_t;

  typedef struct packed {
    logic                valid;
    logic [CORNER_W-1:0] idx;
    logic [TILE_W-1:0]   tx;
    logic [TILE_W-1:0]   ty;
  } corner_t;

  // round half up from Q.16 to Q.8, add offset, saturate to 32 bits
  function automatic logic [31:0] round_sat_q8(input logic signed [EXT_W-1:0] v,
                                               input logic signed [EXT_W-1:0] ofs);
    logic signed [EXT_W-1:0] t;
    t = ((v + EXT_W'(128)) >>> 8) + ofs;
    if (!t[EXT_W-1] && (|t[EXT_W-2:31])) begin
      return 32'h7fff_ffff;
    end else if (t[EXT_W-1] && !(&t[EXT_W-2:31])) begin
      return 32'h8000_0000;
    end
    return t[31:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/cube_corner_transform.sv */
// Top level: cube corner transform, config registers and stream ports
//
//   channel   dir  signals                       contents
//   s_axis    in   tvalid tready tdata[15:0]     tile item
//   m_axis    out  tvalid tready tdata[95:0]     corner item
//                  tuser[2:0] tlast
//   cfg       in   cfg_we_i cfg_idx_i cfg_data_i register write
//
// One corner item leaves per cycle while the output is not stalled; the corner
// sequencer sets that rate and takes the next tile as its eighth corner issues.
// Each corner passes the sequencer register and then the 7 pipeline stages behind it.
// Reset clears all valid bits and loads the register defaults.
// Stalls back up stage by stage; bubbles are squeezed out.
`default_nettype none

module cube_corner_transform (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [5:0] tile_x, [11:6] tile_y, [15:12] zero
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,   // [31:0] screen_x, [63:32] screen_y, [95:64] depth
  output logic [2:0]       m_axis_tuser,   // [2:0] corner_index
  output logic             m_axis_tlast,   // last_corner
  input  wire logic        cfg_we_i,
  input  wire logic [cct_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cct_pkg::REG_W-1:0]     cfg_data_i
);
  import cct_pkg::*;

  cfg_t    cfg_q, cfg_d;
  corner_t crn;
  logic    crn_ready;
  logic [31:0] sx, sy, dep;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CAMERA_X:  cfg_d.camera_x    = cfg_data_i;
        REG_CAMERA_Y:  cfg_d.camera_y    = cfg_data_i;
        REG_ZOOM:      cfg_d.zoom_factor = cfg_data_i;
        REG_COS_YAW:   cfg_d.cos_yaw     = cfg_data_i;
        REG_SIN_YAW:   cfg_d.sin_yaw     = cfg_data_i;
        REG_COS_PITCH: cfg_d.cos_pitch   = cfg_data_i;
        REG_SIN_PITCH: cfg_d.sin_pitch   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x    <= RST_CAMERA_X;
      cfg_q.camera_y    <= RST_CAMERA_Y;
      cfg_q.zoom_factor <= RST_ZOOM;
      cfg_q.cos_yaw     <= RST_COS_YAW;
      cfg_q.sin_yaw     <= RST_SIN_YAW;
      cfg_q.cos_pitch   <= RST_COS_PIT;
      cfg_q.sin_pitch   <= RST_SIN_PIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cct_corner_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tile_valid_i (s_axis_tvalid),
    .tile_ready_o (s_axis_tready),
    .tile_x_i     (s_axis_tdata[TILE_W-1:0]),
    .tile_y_i     (s_axis_tdata[2*TILE_W-1:TILE_W]),
    .crn_o        (crn),
    .crn_ready_i  (crn_ready)
  );

  cct_xform_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .crn_i       (crn),
    .crn_ready_o (crn_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_idx_o     (m_axis_tuser),
    .m_sx_o      (sx),
    .m_sy_o      (sy),
    .m_depth_o   (dep),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {dep, sy, sx};

endmodule

`default_nettype wire

/* hw/rtl/cct_corner_seq.sv */
// Corner sequencer: takes one tile item and issues its eight corners
`default_nettype none

module cct_corner_seq (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     tile_valid_i,
  output logic                          tile_ready_o,
  input  wire logic [cct_pkg::TILE_W-1:0] tile_x_i,
  input  wire logic [cct_pkg::TILE_W-1:0] tile_y_i,
  output cct_pkg::corner_t              crn_o,
  input  wire logic                     crn_ready_i
);
  import cct_pkg::*;

  logic                busy_q, busy_d;
  logic [CORNER_W-1:0] idx_q, idx_d;
  logic [TILE_W-1:0]   tx_q, tx_d, ty_q, ty_d;
  logic                accept;
  logic                adv;

  assign adv          = busy_q && crn_ready_i;
  assign tile_ready_o = !busy_q || (idx_q == LAST_CORNER && crn_ready_i);
  assign accept       = tile_valid_i && tile_ready_o;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    tx_d   = tx_q;
    ty_d   = ty_q;
    if (accept) begin
      busy_d = 1'b1;
      idx_d  = '0;
      // tiles beyond the map edge clamp to the last row/column
      tx_d   = (int'(tile_x_i) > MAP_SIZE - 1) ? TILE_W'(MAP_SIZE - 1) : tile_x_i;
      ty_d   = (int'(tile_y_i) > MAP_SIZE - 1) ? TILE_W'(MAP_SIZE - 1) : tile_y_i;
    end else if (adv) begin
      idx_d = idx_q + CORNER_W'(1);
      if (idx_q == LAST_CORNER) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_q <= tx_d;
    ty_q <= ty_d;
  end

  assign crn_o.valid = busy_q;
  assign crn_o.idx   = idx_q;
  assign crn_o.tx    = tx_q;
  assign crn_o.ty    = ty_q;

`include "cube_corner_transform_macros.svh"

  `CCT_ASSERT_NEXT(a_load_first, clk_i, rst_ni, accept, busy_q && idx_q == '0, "tile not loaded at corner 0")
  `CCT_ASSERT(a_ready_end, clk_i, rst_ni, tile_ready_o |-> (!busy_q || (idx_q == LAST_CORNER && adv)), "ready mid-tile")
  `CCT_ASSERT_NEXT(a_hold_stall, clk_i, rst_ni, busy_q && !crn_ready_i, busy_q && $stable(idx_q) && $stable(tx_q), "corner moved while stalled")

endmodule

`default_nettype wire

/* hw/rtl/cct_xform_pipe.sv */
// Corner transform pipeline: offset, zoom, yaw, pitch, round and saturate
`default_nettype none

module cct_xform_pipe (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cct_pkg::cfg_t    cfg_i,
  input  wire cct_pkg::corner_t crn_i,
  output logic                  crn_ready_o,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output logic [cct_pkg::CORNER_W-1:0] m_idx_o,
  output logic [31:0]           m_sx_o,
  output logic [31:0]           m_sy_o,
  output logic [31:0]           m_depth_o,
  output logic                  m_last_o
);
  import cct_pkg::*;

  localparam logic signed [PR_W:0]   RND_D = (PR_W + 1)'(1 << 13);
  localparam logic signed [QR_W:0]   RND_F = (QR_W + 1)'(1 << 13);
  localparam logic signed [EXT_W-1:0] HALF_W = EXT_W'(VIEW_WIDTH * 128);
  localparam logic signed [EXT_W-1:0] HALF_H = EXT_W'(VIEW_HEIGHT * 128);

  logic [NSTG-1:0] vld_q, vld_d, en;

  // stage 0: relative position
  logic [CORNER_W-1:0]     idx0_q;
  logic signed [POS_W-1:0] px_q, pz_q, px_d, pz_d;
  logic                    yneg_q;
  logic [TILE_W:0]         posx, posz;
  // stage 1: zoom
  logic [CORNER_W-1:0]       idx1_q;
  logic signed [2*POS_W-1:0] mul_x, mul_z;
  logic signed [POS_W-1:0]   zm_s;
  logic signed [AX_W-1:0]    ax_q, az_q;
  logic signed [AY_W-1:0]    ay1_q, ay1_d;
  // stage 2: yaw products
  logic [CORNER_W-1:0]    idx2_q;
  logic signed [PR_W-1:0] p_xc_q, p_zs_q, p_zc_q, p_xs_q;
  logic signed [AY_W-1:0] ay2_q;
  // stage 3: yaw sums
  logic [CORNER_W-1:0]     idx3_q;
  logic signed [PR_W:0]    s_x, s_z, t_x, t_z;
  logic signed [ROT_W-1:0] rx3_q, rz_q;
  logic signed [AY_W-1:0]  ay3_q;
  // stage 4: pitch products
  logic [CORNER_W-1:0]     idx4_q;
  logic signed [QA_W-1:0]  q_ac_q, q_as_q;
  logic signed [QR_W-1:0]  q_rs_q, q_rc_q;
  logic signed [ROT_W-1:0] rx4_q;
  // stage 5: pitch sums
  logic [CORNER_W-1:0]     idx5_q;
  logic signed [QR_W:0]    s_y, s_w, t_y, t_w;
  logic signed [W_W-1:0]   wy_q, wz_q;
  logic signed [ROT_W-1:0] rx5_q;
  // stage 6: output
  logic [CORNER_W-1:0] idx6_q;
  logic [31:0]         sx_q, sy_q, dep_q;
  logic                last_q;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_ready_i;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d[0] = en[0] ? crn_i.valid : vld_q[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign crn_ready_o = en[0];

  // corner offsets: dx on corners 1,2,5,6; dy = -1 on 2,3,6,7; dz on 4..7
  always_comb begin
    posx = {1'b0, crn_i.tx} + {{TILE_W{1'b0}}, crn_i.idx[0] ^ crn_i.idx[1]};
    posz = {1'b0, crn_i.ty} + {{TILE_W{1'b0}}, crn_i.idx[2]};
    px_d = $signed({{(POS_W - TILE_W - 9){1'b0}}, posx, 8'b0})
           - $signed({{(POS_W - REG_W){cfg_i.camera_x[REG_W-1]}}, cfg_i.camera_x});
    pz_d = $signed({{(POS_W - TILE_W - 9){1'b0}}, posz, 8'b0})
           - $signed({{(POS_W - REG_W){cfg_i.camera_y[REG_W-1]}}, cfg_i.camera_y});
  end

  always_comb begin
    zm_s  = $signed({{(POS_W - REG_W){1'b0}}, cfg_i.zoom_factor});
    mul_x = px_q * zm_s;
    mul_z = pz_q * zm_s;
    ay1_d = yneg_q ? -$signed({1'b0, cfg_i.zoom_factor, 8'b0}) : '0;
  end

  always_comb begin
    s_x = (PR_W + 1)'(p_xc_q) + (PR_W + 1)'(p_zs_q) + RND_D;
    s_z = (PR_W + 1)'(p_zc_q) - (PR_W + 1)'(p_xs_q) + RND_D;
    t_x = s_x >>> 14;
    t_z = s_z >>> 14;
    s_y = (QR_W + 1)'(q_ac_q) - (QR_W + 1)'(q_rs_q) + RND_F;
    s_w = (QR_W + 1)'(q_as_q) + (QR_W + 1)'(q_rc_q) + RND_F;
    t_y = s_y >>> 14;
    t_w = s_w >>> 14;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      idx0_q <= crn_i.idx;
      px_q   <= px_d;
      pz_q   <= pz_d;
      yneg_q <= crn_i.idx[1];
    end
    if (en[1]) begin
      idx1_q <= idx0_q;
      ax_q   <= $signed(mul_x[AX_W-1:0]);
      az_q   <= $signed(mul_z[AX_W-1:0]);
      ay1_q  <= ay1_d;
    end
    if (en[2]) begin
      idx2_q <= idx1_q;
      p_xc_q <= ax_q * cfg_i.cos_yaw;
      p_zs_q <= az_q * cfg_i.sin_yaw;
      p_zc_q <= az_q * cfg_i.cos_yaw;
      p_xs_q <= ax_q * cfg_i.sin_yaw;
      ay2_q  <= ay1_q;
    end
    if (en[3]) begin
      idx3_q <= idx2_q;
      rx3_q  <= $signed(t_x[ROT_W-1:0]);
      rz_q   <= $signed(t_z[ROT_W-1:0]);
      ay3_q  <= ay2_q;
    end
    if (en[4]) begin
      idx4_q <= idx3_q;
      q_ac_q <= ay3_q * cfg_i.cos_pitch;
      q_as_q <= ay3_q * cfg_i.sin_pitch;
      q_rs_q <= rz_q * cfg_i.sin_pitch;
      q_rc_q <= rz_q * cfg_i.cos_pitch;
      rx4_q  <= rx3_q;
    end
    if (en[5]) begin
      idx5_q <= idx4_q;
      wy_q   <= $signed(t_y[W_W-1:0]);
      wz_q   <= $signed(t_w[W_W-1:0]);
      rx5_q  <= rx4_q;
    end
    if (en[6]) begin
      idx6_q <= idx5_q;
      sx_q   <= round_sat_q8(EXT_W'(rx5_q), HALF_W);
      sy_q   <= round_sat_q8(EXT_W'(wy_q), HALF_H);
      dep_q  <= round_sat_q8(EXT_W'(wz_q), '0);
      last_q <= (idx5_q == LAST_CORNER);
    end
  end

  assign m_valid_o = vld_q[NSTG-1];
  assign m_idx_o   = idx6_q;
  assign m_sx_o    = sx_q;
  assign m_sy_o    = sy_q;
  assign m_depth_o = dep_q;
  assign m_last_o  = last_q;

`include "cube_corner_transform_macros.svh"

  `CCT_ASSERT(a_full_on_stall, clk_i, rst_ni, !crn_ready_o |-> ((&vld_q) && !m_ready_i), "input stalled with a bubble in the pipe")

endmodule

`default_nettype wire
